// ===== design/mouse_packet_cursor_tracker_defines.svh =====
// Assertion macros for the checker file of the cursor tracker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Clocked property that is ignored while the active-low reset is asserted.
`define MPCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define MPCT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/mpct_pkg.sv =====
package mpct_pkg;

    // Field widths.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BUTTON_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Status bit that marks the data byte as valid.
    localparam int unsigned VALID_BIT = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 2'd1;

    // Screen size after reset.
    localparam logic [BYTE_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [BYTE_W-1:0] ROWS_RESET    = 8'd25;

    // Input transaction: one controller event.
    typedef struct packed {
        logic [BYTE_W-1:0] status_byte;
        logic [BYTE_W-1:0] data_byte;
    } t_in_item;

    // Output transaction: one decoded packet.
    typedef struct packed {
        logic [BYTE_W-1:0]   cursor_x;
        logic [BYTE_W-1:0]   cursor_y;
        logic [BUTTON_W-1:0] button_bits;
        logic [BUTTON_W-1:0] pressed_mask;
        logic [BUTTON_W-1:0] released_mask;
    } t_out_item;

    // Screen geometry handed from the register file to the decoder.
    typedef struct packed {
        logic [BYTE_W-1:0] columns;
        logic [BYTE_W-1:0] rows;
    } t_screen_cfg;

endpackage

// ===== design/mpct_core.sv =====
module mpct_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  mpct_pkg::t_in_item   i_item,
    input  mpct_pkg::t_screen_cfg i_screen,
    output logic                 o_has_result,
    output mpct_pkg::t_out_item  o_result
);

    // Byte positions within a three-byte packet.
    localparam logic [1:0] POS_BUTTONS = 2'd0;
    localparam logic [1:0] POS_DY      = 2'd2;

    logic [1:0]                      r_byte_pos;
    logic [mpct_pkg::BYTE_W-1:0]     r_packet [2];
    logic [mpct_pkg::BYTE_W-1:0]     r_cursor_col;
    logic [mpct_pkg::BYTE_W-1:0]     r_cursor_row;
    logic [mpct_pkg::BUTTON_W-1:0]   r_last_buttons;

    logic                            w_event_ok;
    logic                            w_complete;
    logic signed [9:0]               w_x_sum;
    logic signed [9:0]               w_y_sum;
    logic [mpct_pkg::BYTE_W-1:0]     n_cursor_col;
    logic [mpct_pkg::BYTE_W-1:0]     n_cursor_row;
    logic [mpct_pkg::BUTTON_W-1:0]   w_buttons;

    // Clamp a signed position to 0 .. size-1, where a size of zero acts as one.
    function automatic logic [mpct_pkg::BYTE_W-1:0] clamp_axis(
        input logic signed [9:0]         pos,
        input logic [mpct_pkg::BYTE_W-1:0] size
    );
        logic [mpct_pkg::BYTE_W-1:0] limit;
        limit = (size == '0) ? '0 : size - 8'd1;
        if (pos < 0) begin
            return '0;
        end else if (pos > signed'({2'b00, limit})) begin
            return limit;
        end else begin
            return pos[mpct_pkg::BYTE_W-1:0];
        end
    endfunction

    // The third valid byte of a packet completes it.
    assign w_event_ok   = i_item.status_byte[mpct_pkg::VALID_BIT];
    assign w_complete   = w_event_ok && (r_byte_pos == POS_DY);
    assign o_has_result = w_complete;

    // X moves by the signed delta in byte 1, Y moves against the delta in byte 2.
    assign w_x_sum = signed'({2'b00, r_cursor_col})
                   + signed'({{2{r_packet[1][7]}}, r_packet[1]});
    assign w_y_sum = signed'({2'b00, r_cursor_row})
                   - signed'({{2{i_item.data_byte[7]}}, i_item.data_byte});

    assign n_cursor_col = clamp_axis(w_x_sum, i_screen.columns);
    assign n_cursor_row = clamp_axis(w_y_sum, i_screen.rows);
    assign w_buttons    = r_packet[0][mpct_pkg::BUTTON_W-1:0];

    // Result of the packet that completes with this transaction.
    always_comb begin
        o_result.cursor_x      = n_cursor_col;
        o_result.cursor_y      = n_cursor_row;
        o_result.button_bits   = w_buttons;
        o_result.pressed_mask  = w_buttons & ~r_last_buttons;
        o_result.released_mask = r_last_buttons & ~w_buttons;
    end

    // Packet position, cursor and button history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= POS_BUTTONS;
            r_cursor_col   <= '0;
            r_cursor_row   <= '0;
            r_last_buttons <= '0;
        end else if (i_take && w_event_ok) begin
            if (w_complete) begin
                r_byte_pos     <= POS_BUTTONS;
                r_cursor_col   <= n_cursor_col;
                r_cursor_row   <= n_cursor_row;
                r_last_buttons <= w_buttons;
            end else begin
                r_byte_pos <= r_byte_pos + 2'd1;
            end
        end
    end

    // Buffered header and X bytes; they are always written before use.
    always_ff @(posedge i_clk) begin
        if (i_take && w_event_ok && !w_complete) begin
            r_packet[r_byte_pos[0]] <= i_item.data_byte;
        end
    end

endmodule

// ===== design/mouse_packet_cursor_tracker.sv =====
// Pointing-device packet decoder with a clamped text-screen cursor.
//
// Input channel (i_in_valid / o_in_ready / i_item): one controller event per
// transaction. Events whose status bit 5 is clear are dropped; valid data
// bytes are gathered into three-byte packets (buttons, X delta, Y delta).
// Output channel (o_out_valid / i_out_ready / o_result): one transaction per
// completed packet with the clamped cursor, the buttons and the masks of
// buttons newly pressed and released.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 = screen columns, 1 = screen rows); other indexes are ignored.
//
// The event that completes a packet passes the input register; then the decode
// and clamp feed the result register, which shows the result to the receiver.
// Throughput is one event per cycle unless a finished packet must wait for a
// result register that still holds a stalled result.
// When the receiver stalls, the finished result holds in the result register
// while one more event waits in the input register; events that do not
// finish a packet still drain, so input stalls only if a second result waits.
// Reset clears the cursor to (0, 0), the button history and the packet
// position, empties both registers and restores an 80 by 25 screen.
module mouse_packet_cursor_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mpct_pkg::t_in_item                 i_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mpct_pkg::t_out_item                o_result,
    input  logic                               i_cfg_we,
    input  logic [mpct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mpct_pkg::BYTE_W-1:0]        i_cfg_data
);

    logic                    r_in_valid;
    mpct_pkg::t_in_item      r_in_item;
    logic                    r_out_valid;
    mpct_pkg::t_out_item     r_out_item;
    mpct_pkg::t_screen_cfg   r_screen;

    logic                    n_out_valid;
    logic                    w_out_free;
    logic                    w_take;
    logic                    w_has_result;
    mpct_pkg::t_out_item     w_result;

    // Decoder state and the combinational packet update.
    mpct_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_item       (r_in_item),
        .i_screen     (r_screen),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // An event leaves the input register unless it needs a result slot that is full.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_take      = r_in_valid && (!w_has_result || w_out_free);
    assign o_in_ready  = !r_in_valid || w_take;
    assign n_out_valid = w_take && w_has_result;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_valid) begin
            r_out_item <= w_result;
        end
    end

    // Screen size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen.columns <= mpct_pkg::COLUMNS_RESET;
            r_screen.rows    <= mpct_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mpct_pkg::REG_SCREEN_COLUMNS: r_screen.columns <= i_cfg_data;
                mpct_pkg::REG_SCREEN_ROWS:    r_screen.rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_item;

endmodule

// ===== design/mpct_checker.sv =====
`include "mouse_packet_cursor_tracker_defines.svh"

module mpct_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mpct_pkg::t_out_item o_result
);

    // A stalled result stays put.
    `MPCT_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result),
        "result changed while stalled")

    // Pressed and released masks agree with the reported buttons.
    `MPCT_ASSERT(a_masks, i_clk, i_rst_n,
        o_out_valid |-> ((o_result.pressed_mask & o_result.released_mask) == '0)
            && ((o_result.pressed_mask & ~o_result.button_bits) == '0)
            && ((o_result.released_mask & o_result.button_bits) == '0),
        "button masks inconsistent")

    // A result showing up after an idle output follows an accepted input event.
    `MPCT_ASSERT(a_no_phantom, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2),
        "result without a matching input transaction")

    // Reset empties both registers.
    `MPCT_ASSERT_RST(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid && o_in_ready,
        "pipeline not empty after reset")

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result)
);

// ===== tb/sv/testbench.sv =====
module testbench;

    // Data-valid flag of the status byte, and the two register indexes that
    // decode to nothing.
    localparam logic [mpct_pkg::BYTE_W-1:0]    VALID_FLAG   = 8'h01 << mpct_pkg::VALID_BIT;
    localparam logic [mpct_pkg::CFG_IDX_W-1:0] UNUSED_REG_A = 2'd2;
    localparam logic [mpct_pkg::CFG_IDX_W-1:0] UNUSED_REG_B = 2'd3;

    // The pipeline is two deep; the drain wait also covers an event that is
    // still in flight but finishes no packet.
    localparam int DRAIN_CYCLES  = 6;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PERCENT  = 14;

    // Predicts the cursor tracker and holds the decoded packets still owed.
    class cursor_scoreboard;
        logic [mpct_pkg::BYTE_W-1:0]   columns;
        logic [mpct_pkg::BYTE_W-1:0]   rows;
        logic [1:0]                    byte_pos;
        logic [mpct_pkg::BYTE_W-1:0]   pkt [2];
        logic [mpct_pkg::BYTE_W-1:0]   col;
        logic [mpct_pkg::BYTE_W-1:0]   row;
        logic [mpct_pkg::BUTTON_W-1:0] last_buttons;
        mpct_pkg::t_out_item           packet_q[$];
        int                            mismatches;
        int                            events;
        int                            packets;

        function new();
            columns      = mpct_pkg::COLUMNS_RESET;
            rows         = mpct_pkg::ROWS_RESET;
            byte_pos     = 2'd0;
            pkt[0]       = '0;
            pkt[1]       = '0;
            col          = '0;
            row          = '0;
            last_buttons = '0;
            mismatches   = 0;
            events       = 0;
            packets      = 0;
        endfunction

        function void write_reg(logic [mpct_pkg::CFG_IDX_W-1:0] idx,
                                logic [mpct_pkg::BYTE_W-1:0] value);
            if (idx == mpct_pkg::REG_SCREEN_COLUMNS) columns = value;
            else if (idx == mpct_pkg::REG_SCREEN_ROWS) rows = value;
        endfunction

        // A zero screen size behaves like a size of one.
        function logic [mpct_pkg::BYTE_W-1:0] clamp_axis(int pos,
                                                          logic [mpct_pkg::BYTE_W-1:0] size);
            int limit;
            limit = (size == 0) ? 0 : int'(size) - 1;
            if (pos < 0) return '0;
            if (pos > limit) return 8'(limit);
            return 8'(pos);
        endfunction

        // Called for every accepted input transaction.
        function void note_event(mpct_pkg::t_in_item ev);
            mpct_pkg::t_out_item           res;
            logic [mpct_pkg::BUTTON_W-1:0] buttons;
            events++;
            if (!ev.status_byte[mpct_pkg::VALID_BIT]) return;
            if (byte_pos < 2'd2) begin
                pkt[byte_pos[0]] = ev.data_byte;
                byte_pos++;
                return;
            end
            byte_pos = 2'd0;
            col = clamp_axis(int'(col) + int'($signed(pkt[1])), columns);
            row = clamp_axis(int'(row) - int'($signed(ev.data_byte)), rows);
            buttons = pkt[0][mpct_pkg::BUTTON_W-1:0];
            res.cursor_x      = col;
            res.cursor_y      = row;
            res.button_bits   = buttons;
            res.pressed_mask  = buttons & ~last_buttons;
            res.released_mask = last_buttons & ~buttons;
            last_buttons = buttons;
            packet_q.push_back(res);
        endfunction

        function void report(string what);
            if (mismatches < REPORT_LIMIT) $display("mismatch: %s", what);
            mismatches++;
        endfunction

        // Called for every accepted output transaction.
        function void check_result(mpct_pkg::t_out_item got);
            mpct_pkg::t_out_item want;
            if (packet_q.size() == 0) begin
                report($sformatf("result x=%0d y=%0d btn=%b with nothing expected",
                                 got.cursor_x, got.cursor_y, got.button_bits));
                return;
            end
            want = packet_q.pop_front();
            packets++;
            if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
                got.button_bits !== want.button_bits ||
                got.pressed_mask !== want.pressed_mask ||
                got.released_mask !== want.released_mask) begin
                report($sformatf({"packet %0d: expected x=%0d y=%0d btn=%b prs=%b rel=%b, ",
                                  "got x=%0d y=%0d btn=%b prs=%b rel=%b"}, packets,
                                 want.cursor_x, want.cursor_y, want.button_bits,
                                 want.pressed_mask, want.released_mask,
                                 got.cursor_x, got.cursor_y, got.button_bits,
                                 got.pressed_mask, got.released_mask));
            end
        endfunction

        function int pending();
            return packet_q.size();
        endfunction

        // Packets that never came out count as failures.
        function void flush_leftover();
            while (packet_q.size() != 0) begin
                void'(packet_q.pop_front());
                report("expected packet never arrived");
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    mpct_pkg::t_in_item             in_item     = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    mpct_pkg::t_out_item            result;
    logic                           cfg_we      = 1'b0;
    logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [mpct_pkg::BYTE_W-1:0]    cfg_data    = '0;
    bit                             steady_phase = 1'b0;
    int                             stall_cycles = 0;
    int                             screen_settings = 1;
    cursor_scoreboard               sb;

    mouse_packet_cursor_tracker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_item      (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure; none during the steady stretch.
    always @(posedge clk) begin
        out_ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Output monitor.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(result);
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("[mouse_packet_cursor_tracker] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic mpct_pkg::t_in_item make_event(logic [mpct_pkg::BYTE_W-1:0] status,
                                                      logic [mpct_pkg::BYTE_W-1:0] data);
        mpct_pkg::t_in_item ev;
        ev.status_byte = status;
        ev.data_byte   = data;
        return ev;
    endfunction

    // Mostly valid bytes with random content, some of them set to 7F, 80, 00 or
    // FF; the rest are dropped events with random other status bits.
    function automatic mpct_pkg::t_in_item random_event();
        mpct_pkg::t_in_item ev;
        int                 pick;
        pick = $urandom_range(0, 99);
        ev.status_byte = 8'($urandom_range(0, 255));
        ev.data_byte   = 8'($urandom_range(0, 255));
        if (pick < 12) begin
            ev.status_byte[mpct_pkg::VALID_BIT] = 1'b0;
        end else begin
            ev.status_byte[mpct_pkg::VALID_BIT] = 1'b1;
            if (pick < 30) begin
                case ($urandom_range(0, 3))
                    0: ev.data_byte = 8'h7F;
                    1: ev.data_byte = 8'h80;
                    2: ev.data_byte = 8'h00;
                    default: ev.data_byte = 8'hFF;
                endcase
            end
        end
        return ev;
    endfunction

    // Presents one event, with optional idle cycles ahead of it, and returns
    // once it has been accepted.
    task automatic send_event(input mpct_pkg::t_in_item ev);
        while (!steady_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (!in_ready);
        sb.note_event(ev);
    endtask

    task automatic send_packet(input logic [mpct_pkg::BYTE_W-1:0] head, dx, dy);
        send_event(make_event(VALID_FLAG, head));
        send_event(make_event(VALID_FLAG, dx));
        send_event(make_event(VALID_FLAG, dy));
    endtask

    // Drives the cursor to the far corner of a full-size screen, starting on
    // a packet boundary.
    task automatic push_corner();
        while (sb.byte_pos != 2'd0)
            send_event(make_event(VALID_FLAG, 8'($urandom_range(0, 255))));
        send_packet(8'h00, 8'h7F, 8'h80);
        send_packet(8'h00, 8'h7F, 8'h80);
    endtask

    // Sends the given number of random events, dropped ones included.
    task automatic random_phase(input int event_count);
        mpct_pkg::t_in_item ev;
        int                 sent;
        sent = 0;
        while (sent < event_count) begin
            ev = random_event();
            send_event(ev);
            sent++;
        end
    endtask

    // Waits until every owed packet is out and the pipeline has emptied.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both screen registers, and optionally the unused indexes too.
    task automatic set_screen(input logic [mpct_pkg::BYTE_W-1:0] cols, rows,
                              input bit touch_unused);
        logic [mpct_pkg::BYTE_W-1:0] junk;
        junk = 8'($urandom_range(0, 255));
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= mpct_pkg::REG_SCREEN_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_index <= mpct_pkg::REG_SCREEN_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        if (touch_unused) begin
            cfg_index <= UNUSED_REG_A;
            cfg_data  <= junk;
            @(posedge clk);
            cfg_index <= UNUSED_REG_B;
            cfg_data  <= ~junk;
            @(posedge clk);
            sb.write_reg(UNUSED_REG_A, junk);
            sb.write_reg(UNUSED_REG_B, ~junk);
        end
        cfg_we <= 1'b0;
        sb.write_reg(mpct_pkg::REG_SCREEN_COLUMNS, cols);
        sb.write_reg(mpct_pkg::REG_SCREEN_ROWS, rows);
        screen_settings++;
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset screen size.
        send_event(make_event(8'h00, 8'hFF));          // dropped, every data bit set
        send_event(make_event(8'hDF, 8'h00));          // dropped, all other status bits
        send_packet(8'h07, 8'h7F, 8'h80);              // clamp high, all buttons pressed
        send_packet(8'hF8, 8'h80, 8'h7F);              // flag bits only, clamp low
        // Packet interleaved with dropped events.
        send_event(make_event(VALID_FLAG, 8'h05));
        send_event(make_event(8'hDF, 8'hAA));
        send_event(make_event(8'hFF, 8'h03));
        send_event(make_event(8'h00, 8'h11));
        send_event(make_event(VALID_FLAG | 8'h01, 8'hFF));
        send_packet(8'hFA, 8'h00, 8'h00);              // flags with buttons, no motion
        send_packet(8'h01, 8'hFF, 8'h01);
        send_packet(8'h06, 8'h4C, 8'hEA);

        random_phase(200);

        // Largest screen, cursor pushed to the corner, unused indexes written.
        set_screen(8'd255, 8'd255, 1'b1);
        push_corner();
        random_phase(250);
        push_corner();

        // Shrunk screen: the cursor stays out of range until the next packet.
        set_screen(8'd1, 8'd1, 1'b0);
        random_phase(150);

        // Zero sizes behave like one.
        set_screen(8'd0, 8'd0, 1'b1);
        random_phase(150);

        // Long stretch with no idling on either side.
        set_screen(8'd255, 8'd1, 1'b0);
        steady_phase = 1'b1;
        random_phase(200);
        steady_phase = 1'b0;

        set_screen(8'd1, 8'd255, 1'b0);
        random_phase(200);

        repeat (3) begin
            set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b1);
            random_phase(180);
        end

        wait_idle();
        sb.flush_leftover();
        $display("Sent %0d controller events and checked %0d packets across %0d screen sizes,",
                 sb.events, sb.packets, screen_settings);
        $display("including zero, one and full-size screens and a shrunk screen; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[mouse_packet_cursor_tracker] OK");
        end else begin
            $display("[mouse_packet_cursor_tracker] ERROR");
        end
        $finish;
    end
endmodule
